### hdl/swmm_pkg.sv
// Shared types and constants for the sliding window min/max block.
package swmm_pkg;

	localparam int SAMPLE_W = 32;
	localparam int CFG_W    = 7;

	localparam logic [CFG_W-1:0] WS_RESET = 7'd4;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	localparam sample_t INT_MAX = 32'sh7FFF_FFFF;
	localparam sample_t INT_MIN = 32'sh8000_0000;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_HOLD
	} state_t;

	// Commands broadcast from the sequencer to every cell.
	typedef struct packed {
		logic shift;
		logic scan;
	} cell_ctl_t;

endpackage

### hdl/swmm_in_if.sv
// Input sample channel: valid, ready, start flag and sample value.
interface swmm_in_if import swmm_pkg::*; ();
	logic    valid;
	logic    ready;
	logic    start_req;
	sample_t sample;

	modport source(output valid, output start_req, output sample, input ready);
	modport sink(input valid, input start_req, input sample, output ready);
endinterface

### hdl/swmm_out_if.sv
// Result channel: valid, ready and the window minimum and maximum.
interface swmm_out_if import swmm_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t min_value;
	sample_t max_value;

	modport source(output valid, output min_value, output max_value, input ready);
	modport sink(input valid, input min_value, input max_value, output ready);
endinterface

### hdl/swmm_cell.sv
// One window cell: holds a sample and a partial min/max passed toward cell zero.
module swmm_cell import swmm_pkg::*; #(
	parameter int IDX  = 0,
	parameter int SZ_W = 7
) (
	input  logic            clk,
	input  cell_ctl_t       ctl,
	input  logic [SZ_W-1:0] eff_m1,
	input  sample_t         prev_val,
	input  sample_t         next_min,
	input  sample_t         next_max,
	output sample_t         val,
	output sample_t         pmin,
	output sample_t         pmax
);

	localparam logic [SZ_W-1:0] IDX_V = SZ_W'(IDX);

	sample_t val_q;
	sample_t pmin_q;
	sample_t pmax_q;
	logic    tail;

	// The oldest cell of the window and every cell past it start the chain.
	assign tail = (IDX_V >= eff_m1);

	// Samples shift one cell deeper per accepted beat.
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			val_q <= prev_val;
		end
	end

	// Each scan cycle folds this cell's sample into its neighbor's partial; a tail cell restarts it from its own sample.
	always_ff @(posedge clk) begin
		if (ctl.scan) begin
			if (tail) begin
				pmin_q <= val_q;
				pmax_q <= val_q;
			end else begin
				pmin_q <= (val_q < next_min) ? val_q : next_min;
				pmax_q <= (val_q > next_max) ? val_q : next_max;
			end
		end
	end

	assign val  = val_q;
	assign pmin = pmin_q;
	assign pmax = pmax_q;

endmodule

### hdl/swmm_ctrl.sv
// Sequencer: window size register, fill count, scan counter and result handshake.
module swmm_ctrl import swmm_pkg::*; #(
	parameter int WINDOW_MAX = 64,
	parameter int SZ_W       = 7
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	input  logic             smp_valid,
	input  logic             smp_start,
	output logic             smp_ready,
	input  logic             res_ready,
	output logic             res_valid,
	output cell_ctl_t        ctl,
	output logic             load_out,
	output logic [SZ_W-1:0]  eff_m1
);

	localparam int CMP_W = (SZ_W > CFG_W) ? SZ_W : CFG_W;

	state_t           state_q;
	state_t           state_nx;
	logic [CFG_W-1:0] ws_q;
	logic [SZ_W-1:0]  fill_q;
	logic [SZ_W-1:0]  cnt_q;
	logic             res_valid_q;
	logic [CMP_W-1:0] ws_ext;
	logic [CMP_W-1:0] eff_ext;
	logic [SZ_W-1:0]  eff;
	logic [SZ_W-1:0]  fill_base;
	logic [SZ_W-1:0]  fill_nx;
	logic             accept;
	logic             full_nx;
	logic             out_free;

	// Effective window size: zero counts as one, large values saturate.
	always_comb begin
		ws_ext = CMP_W'(ws_q);
		priority if (ws_q == '0) begin
			eff_ext = CMP_W'(1);
		end else if (ws_ext > CMP_W'(WINDOW_MAX)) begin
			eff_ext = CMP_W'(WINDOW_MAX);
		end else begin
			eff_ext = ws_ext;
		end
	end

	assign eff    = eff_ext[SZ_W-1:0];
	assign eff_m1 = eff - SZ_W'(1);

	// Fill count after the incoming beat, restarted by the start flag.
	assign accept    = smp_valid && smp_ready;
	assign fill_base = smp_start ? '0 : fill_q;
	assign fill_nx   = (fill_base < eff) ? fill_base + SZ_W'(1) : fill_base;
	assign full_nx   = (fill_nx == eff);
	assign out_free  = !res_valid_q || res_ready;

	// Next state.
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && full_nx) begin
					state_nx = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (cnt_q == SZ_W'(1)) begin
					state_nx = ST_HOLD;
				end
			end
			ST_HOLD: begin
				if (out_free) begin
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	// State outputs.
	always_comb begin
		smp_ready = 1'b0;
		ctl.shift = 1'b0;
		ctl.scan  = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				smp_ready = 1'b1;
				ctl.shift = smp_valid;
			end
			ST_SCAN: begin
				ctl.scan = 1'b1;
			end
			ST_HOLD: begin
				load_out = out_free;
			end
			default: begin
				smp_ready = 1'b0;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ws_q        <= WS_RESET;
			fill_q      <= '0;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cfg_we) begin
				ws_q   <= cfg_wdata;
				fill_q <= '0;
			end else if (accept) begin
				fill_q <= fill_nx;
			end
			if (accept) begin
				cnt_q <= eff;
			end else if (state_q == ST_SCAN) begin
				cnt_q <= cnt_q - SZ_W'(1);
			end
			if (load_out) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = res_valid_q;

	// The scan never runs out of iterations before handing off.
	a_scan_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (cnt_q != '0))
		else $error("scan counter reached zero inside scan");

	// A result is never loaded over one that has not been taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> (!res_valid_q || res_ready))
		else $error("result register overwritten");

	// The fill count never exceeds the effective window size while idle.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && !$past(cfg_we)) |-> (fill_q <= eff || $past(cfg_we, 2)))
		else $error("fill count above window size");

	// Loading a result always returns the sequencer to idle.
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> (state_q == ST_IDLE))
		else $error("sequencer did not return to idle after load");

endmodule

### hdl/sliding_window_min_max_core.sv
// Sliding window min/max: sample shift chain of cells with a folding min/max scan.
// After a beat that fills the window, the sequencer scans the cells, then loads the result register.
// Throughput: one sample per cycle while the window fills; after a result-producing beat the block
// takes no sample during the scan and while the previous result is still waiting to be taken.
// The scan covers the effective window size: zero counts as one, WINDOW_MAX at most.
// Reset (arst_n low, asynchronous): window size 4, empty window, no result pending.
module sliding_window_min_max_core import swmm_pkg::*; #(
	parameter int WINDOW_MAX = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	swmm_in_if.sink          smp,
	swmm_out_if.source       res
);

	localparam int SZ_W = $clog2(WINDOW_MAX + 1);

	cell_ctl_t       ctl;
	logic            load_out;
	logic [SZ_W-1:0] eff_m1;
	sample_t         val   [WINDOW_MAX];
	sample_t         pmin  [WINDOW_MAX];
	sample_t         pmax  [WINDOW_MAX];
	sample_t         min_q;
	sample_t         max_q;

	// Sequencer.
	swmm_ctrl #(
		.WINDOW_MAX(WINDOW_MAX),
		.SZ_W      (SZ_W)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.smp_valid(smp.valid),
		.smp_start(smp.start_req),
		.smp_ready(smp.ready),
		.res_ready(res.ready),
		.res_valid(res.valid),
		.ctl      (ctl),
		.load_out (load_out),
		.eff_m1   (eff_m1)
	);

	// Chain of cells: cell zero holds the newest sample.
	for (genvar c = 0; c < WINDOW_MAX; c++) begin : g_cell
		sample_t prev_v;
		sample_t nmin;
		sample_t nmax;

		if (c == 0) begin : g_head
			assign prev_v = smp.sample;
		end else begin : g_body
			assign prev_v = val[c-1];
		end

		if (c == WINDOW_MAX - 1) begin : g_last
			assign nmin = INT_MAX;
			assign nmax = INT_MIN;
		end else begin : g_inner
			assign nmin = pmin[c+1];
			assign nmax = pmax[c+1];
		end

		swmm_cell #(
			.IDX (c),
			.SZ_W(SZ_W)
		) u_cell (
			.clk     (clk),
			.ctl     (ctl),
			.eff_m1  (eff_m1),
			.prev_val(prev_v),
			.next_min(nmin),
			.next_max(nmax),
			.val     (val[c]),
			.pmin    (pmin[c]),
			.pmax    (pmax[c])
		);
	end

	// Result register, loaded from the head of the chain.
	always_ff @(posedge clk) begin
		if (load_out) begin
			min_q <= pmin[0];
			max_q <= pmax[0];
		end
	end

	assign res.min_value = min_q;
	assign res.max_value = max_q;

endmodule
